/* rtl/jets_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the Julia escape-time unit.
// Holds the fractional log2 table, built at elaboration. No dependencies.
package jets_pkg;

	localparam int COORD_W         = 32;
	localparam int COORD_FRAC_BITS = 28;
	localparam int ITER_WIDTH      = 16;
	localparam int LOG_TABLE_DEPTH = 64;

	localparam int THR_W     = 17;
	localparam int LIMIT_W   = 16;
	localparam int CNT_OUT_W = 16;
	localparam int SMOOTH_W  = 33;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam int ZW     = COORD_FRAC_BITS + 20;
	localparam int HALF_W = (ZW + 1) / 2;
	localparam int MAG_W  = 2 * HALF_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SQ_W   = PROD_W - COORD_FRAC_BITS;
	localparam int MSUM_W = 64;
	localparam int SQX_W  = (SQ_W > MSUM_W) ? SQ_W : MSUM_W;
	localparam int LIMX_W = (LIMIT_W > ITER_WIDTH) ? LIMIT_W : ITER_WIDTH;

	localparam int NORM_W    = 64;
	localparam int POS_W     = 6;
	localparam int STEP_W    = $clog2(POS_W);
	localparam int FRAC_Q    = 16;
	localparam int LOG_IDX_W = (LOG_TABLE_DEPTH > 1) ? $clog2(LOG_TABLE_DEPTH) : 1;
	localparam int IDXP_W    = 32 + $clog2(LOG_TABLE_DEPTH + 1);
	localparam int LOG_TAB_W = 17;
	localparam int LG_W      = POS_W + 2 + FRAC_Q + 1;
	localparam int SMX_W     = (ITER_WIDTH + FRAC_Q + 2 > SMOOTH_W) ?
	                           (ITER_WIDTH + FRAC_Q + 2) : SMOOTH_W;

	localparam logic [ZW-1:0]       Z_MAX  = {1'b0, {(ZW-1){1'b1}}};
	localparam logic [ZW-1:0]       Z_MIN  = {1'b1, {(ZW-1){1'b0}}};
	localparam logic [MSUM_W-2:0]   SQ_CAP = {1'b1, {(MSUM_W-2){1'b0}}};
	localparam int LOG2_LN2_NEG_Q16 = 34653;
	localparam int TWO_Q16          = 2 * 65536;
	localparam int SMOOTH_BIAS      = TWO_Q16 + LOG2_LN2_NEG_Q16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_RE       = 2'd0,
		REG_C_IM       = 2'd1,
		REG_ESC_RADIUS = 2'd2,
		REG_MAX_ITER   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [NORM_W-1:0] x;
		logic [POS_W-1:0]  frac;
	} log_req_t;

	typedef struct packed {
		logic            done;
		logic [LG_W-1:0] lg;
	} log_rsp_t;

	typedef logic [LOG_TAB_W-1:0] log_tab_t [LOG_TABLE_DEPTH];

	// log2(1 + k/D) in Q16.16 by repeated squaring in Q1.30
	function automatic log_tab_t build_log_tab();
		log_tab_t    tab;
		logic [63:0] v;
		logic [17:0] r;
		for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
			v = (64'd1 << 30) + ((64'(k) << 30) / LOG_TABLE_DEPTH);
			r = '0;
			for (int i = 0; i < 17; i++) begin
				v = (v * v) >> 30;
				r = r << 1;
				if (v >= (64'd1 << 31)) begin
					v = v >> 1;
					r[0] = 1'b1;
				end
			end
			tab[k] = LOG_TAB_W'((r + 18'd1) >> 1);
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

/* rtl/jets_mul.sv */
`timescale 1ns / 1ps
// Shared unsigned multiplier: one half-by-half partial product per cycle,
// four passes accumulated into the full product. Depends on jets_pkg.
module jets_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  jets_pkg::mul_req_t req,
	output jets_pkg::mul_rsp_t rsp
);
	import jets_pkg::*;

	logic              busy_q;
	logic [1:0]        step_q;
	logic [MAG_W-1:0]  a_q;
	logic [MAG_W-1:0]  b_q;
	logic [HALF_W-1:0] opa;
	logic [HALF_W-1:0] opb;
	logic [MAG_W-1:0]  pp;
	logic [MAG_W-1:0]  pp_s1;
	logic [1:0]        sh_s1;
	logic              vld_s1;
	logic              last_s1;
	logic [PROD_W-1:0] pp_ext;
	logic [PROD_W-1:0] acc_q;
	logic              done_q;

	assign opa = step_q[1] ? a_q[MAG_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign opb = step_q[0] ? b_q[MAG_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign pp  = opa * opb;

	always_comb begin
		case (sh_s1)
			2'd0:    pp_ext = PROD_W'(pp_s1);
			2'd1:    pp_ext = PROD_W'(pp_s1) << HALF_W;
			default: pp_ext = PROD_W'(pp_s1) << MAG_W;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (step_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		pp_s1 <= pp;
		sh_s1 <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
		if (req.start)
			acc_q <= '0;
		else if (vld_s1)
			acc_q <= acc_q + pp_ext;
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !vld_s1 && !last_s1)
		else $error("multiplier restarted mid-product");

endmodule

/* rtl/jets_log2.sv */
`timescale 1ns / 1ps
// Iterative log2 in signed Q8.16: binary-search leading-one normaliser, one step
// a cycle, then fractional table lookup. Depends on jets_pkg.
module jets_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  jets_pkg::log_req_t req,
	output jets_pkg::log_rsp_t rsp
);
	import jets_pkg::*;

	localparam logic [POS_W:0] HALF_NORM = (POS_W+1)'(NORM_W / 2);
	localparam logic [POS_W:0] FULL_NORM = (POS_W+1)'(NORM_W);

	logic              run_q;
	logic              look_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NORM_W-1:0] x_q;
	logic [POS_W-1:0]  sh_q;
	logic [POS_W-1:0]  frac_q;
	logic [LG_W-1:0]   lg_q;
	logic [POS_W:0]    step_w;
	logic              top_zero;
	logic [IDXP_W-1:0] idx_prod;
	logic [LOG_IDX_W-1:0] idx;
	logic signed [POS_W+1:0] pdiff;
	logic [LG_W-1:0]   lg;

	assign step_w   = HALF_NORM >> step_q;
	assign top_zero = (x_q >> (FULL_NORM - step_w)) == '0;

	// fraction below the leading one, scaled to the table depth
	assign idx_prod = IDXP_W'(x_q[NORM_W-2:NORM_W-33]) * IDXP_W'(LOG_TABLE_DEPTH);
	assign idx      = idx_prod[32 +: LOG_IDX_W];
	assign pdiff    = signed'({2'b00, ~sh_q}) - signed'({2'b00, frac_q});
	assign lg       = {{(LG_W-POS_W-2-FRAC_Q){pdiff[POS_W+1]}}, pdiff, {FRAC_Q{1'b0}}}
	                + LG_W'(LOG_TAB[idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			look_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= look_q;
			look_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(POS_W - 1)) begin
					run_q  <= 1'b0;
					look_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= req.x;
			frac_q <= req.frac;
			sh_q   <= '0;
		end else if (run_q && top_zero) begin
			x_q  <= x_q << step_w;
			sh_q <= sh_q + step_w[POS_W-1:0];
		end
		if (look_q)
			lg_q <= lg;
	end

	assign rsp.done = done_q;
	assign rsp.lg   = lg_q;

	a_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		look_q |-> x_q[NORM_W-1])
		else $error("normaliser finished without leading one at the top");

endmodule

/* rtl/julia_escape_time_smooth_unit.sv */
`timescale 1ns / 1ps
// One item is a start point z0; the unit iterates z = z*z + c until |z|^2 exceeds
// escape_radius_sq or max_iterations is reached, then returns the count, the escape
// flag and the smooth value it + 2 - log2(ln|z|^2) in Q16.16, or just the count in
// Q16.16 if z did not escape. Every 48x48 product goes through one shared 24x24
// multiplier in four passes; an iteration takes three products plus check and
// update, the start point adds its two squares and a check, and an escaped item
// adds two log2 evaluations. One item at a time; the result sits in an output
// register, so the next item can be taken while it waits. Depends on jets_pkg,
// jets_mul and jets_log2.
module julia_escape_time_smooth_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [jets_pkg::COORD_W-1:0]    z0_re,
	input  logic signed [jets_pkg::COORD_W-1:0]    z0_im,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [jets_pkg::CNT_OUT_W-1:0]         iteration_count,
	output logic                                   escaped,
	output logic signed [jets_pkg::SMOOTH_W-1:0]   smooth_value,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [jets_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [jets_pkg::CFG_W-1:0]             cfg_data
);
	import jets_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CHECK,
		ST_CROSS,
		ST_UPDATE,
		ST_LOG_MAG,
		ST_LOG_L,
		ST_DONE
	} state_t;

	function automatic logic [ZW-1:0] sat_z(input logic [ZW+1:0] v);
		logic [ZW-1:0] r;
		if (v[ZW+1:ZW-1] == 3'b000 || v[ZW+1:ZW-1] == 3'b111)
			r = v[ZW-1:0];
		else if (v[ZW+1])
			r = Z_MIN;
		else
			r = Z_MAX;
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] abs_z(input logic [ZW-1:0] v);
		logic [ZW-1:0] m;
		m = v[ZW-1] ? (~v + 1'b1) : v;
		return MAG_W'(m);
	endfunction

	// configuration
	logic [COORD_W-1:0] c_re_q;
	logic [COORD_W-1:0] c_im_q;
	logic [THR_W-1:0]   esc_rad_q;
	logic [LIMIT_W-1:0] max_iter_q;

	// working state
	state_t              state_q;
	logic [ZW-1:0]       re_q;
	logic [ZW-1:0]       im_q;
	logic [ZW-1:0]       rr_q;
	logic [ZW-1:0]       ii_q;
	logic [ZW-1:0]       ri_q;
	logic [MSUM_W-2:0]   mre_q;
	logic [MSUM_W-1:0]   mag_q;
	logic [ITER_WIDTH-1:0] counter_q;
	logic [ITER_WIDTH-1:0] limit_q;
	logic                first_q;
	logic                esc_flag_q;
	logic [SMOOTH_W-1:0] smooth_res_q;
	mul_req_t            mul_req_q;
	log_req_t            log_req_q;
	logic                out_valid_q;
	logic [CNT_OUT_W-1:0] iteration_count_q;
	logic                escaped_q;
	logic [SMOOTH_W-1:0] smooth_value_q;

	mul_rsp_t mul_rsp;
	log_rsp_t log_rsp;

	logic [ZW-1:0]         z0_re_x;
	logic [ZW-1:0]         z0_im_x;
	logic [LIMX_W-1:0]     max_ext;
	logic [LIMX_W-1:0]     cnt_max_ext;
	logic [ITER_WIDTH-1:0] limit;
	logic [SQ_W-1:0]       sq;
	logic [SQX_W-1:0]      sq_x;
	logic [ZW-1:0]         sq_zcap;
	logic [MSUM_W-2:0]     sq_mcap;
	logic                  cross_neg;
	logic [SQX_W-1:0]      cross_cap;
	logic [ZW-1:0]         ri_mag;
	logic [ZW-1:0]         ri;
	logic [ZW+1:0]         c_re_x;
	logic [ZW+1:0]         c_im_x;
	logic [ZW-1:0]         nre;
	logic [ZW-1:0]         dbl;
	logic [ZW-1:0]         nim;
	logic [MSUM_W-1:0]     thr;
	logic [ITER_WIDTH-1:0] cnt_nx;
	logic [LG_W-1:0]       lg_pos;
	logic [SMX_W-1:0]      lg_x;
	logic [SMX_W-1:0]      smooth_full;

	assign z0_re_x     = {{(ZW-COORD_W){z0_re[COORD_W-1]}}, z0_re};
	assign z0_im_x     = {{(ZW-COORD_W){z0_im[COORD_W-1]}}, z0_im};
	assign max_ext     = LIMX_W'(max_iter_q);
	assign cnt_max_ext = LIMX_W'({ITER_WIDTH{1'b1}});
	assign limit       = ITER_WIDTH'((max_ext > cnt_max_ext) ? cnt_max_ext : max_ext);

	assign sq      = mul_rsp.prod[PROD_W-1:COORD_FRAC_BITS];
	assign sq_x    = SQX_W'(sq);
	assign sq_zcap = (sq_x > SQX_W'(Z_MAX)) ? Z_MAX : sq_x[ZW-1:0];
	assign sq_mcap = (sq_x > SQX_W'(SQ_CAP)) ? SQ_CAP : sq_x[MSUM_W-2:0];

	// negative products may reach the most negative value
	assign cross_neg = re_q[ZW-1] ^ im_q[ZW-1];
	assign cross_cap = SQX_W'(Z_MAX) + SQX_W'(cross_neg);
	assign ri_mag    = (sq_x > cross_cap) ? cross_cap[ZW-1:0] : sq_x[ZW-1:0];
	assign ri        = cross_neg ? (~ri_mag + 1'b1) : ri_mag;

	assign c_re_x = {{(ZW+2-COORD_W){c_re_q[COORD_W-1]}}, c_re_q};
	assign c_im_x = {{(ZW+2-COORD_W){c_im_q[COORD_W-1]}}, c_im_q};
	assign nre    = sat_z({2'b00, rr_q} - {2'b00, ii_q} + c_re_x);
	assign dbl    = sat_z({ri_q[ZW-1], ri_q, 1'b0});
	assign nim    = sat_z({{2{dbl[ZW-1]}}, dbl} + c_im_x);

	assign thr    = MSUM_W'({esc_rad_q, {COORD_FRAC_BITS{1'b0}}});
	assign cnt_nx = counter_q + ITER_WIDTH'(!first_q);

	assign lg_pos = (log_rsp.lg[LG_W-1] || log_rsp.lg == '0) ? LG_W'(1) : log_rsp.lg;
	assign lg_x   = {{(SMX_W-LG_W){log_rsp.lg[LG_W-1]}}, log_rsp.lg};
	assign smooth_full = SMX_W'({counter_q, {FRAC_Q{1'b0}}}) + SMX_W'(SMOOTH_BIAS) - lg_x;

	jets_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.rsp    (mul_rsp)
	);

	jets_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req_q),
		.rsp    (log_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_re_q     <= '0;
			c_im_q     <= '0;
			esc_rad_q  <= THR_W'(4);
			max_iter_q <= LIMIT_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_C_RE:       c_re_q     <= cfg_data;
				REG_C_IM:       c_im_q     <= cfg_data;
				REG_ESC_RADIUS: esc_rad_q  <= cfg_data[THR_W-1:0];
				REG_MAX_ITER:   max_iter_q <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			re_q              <= '0;
			im_q              <= '0;
			rr_q              <= '0;
			ii_q              <= '0;
			ri_q              <= '0;
			mre_q             <= '0;
			mag_q             <= '0;
			counter_q         <= '0;
			limit_q           <= '0;
			first_q           <= 1'b0;
			esc_flag_q        <= 1'b0;
			smooth_res_q      <= '0;
			mul_req_q         <= '0;
			log_req_q         <= '0;
			out_valid_q       <= 1'b0;
			iteration_count_q <= '0;
			escaped_q         <= 1'b0;
			smooth_value_q    <= '0;
		end else begin
			mul_req_q.start <= 1'b0;
			log_req_q.start <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						re_q       <= z0_re_x;
						im_q       <= z0_im_x;
						counter_q  <= '0;
						limit_q    <= limit;
						first_q    <= 1'b1;
						esc_flag_q <= 1'b0;
						if (limit == '0) begin
							state_q <= ST_DONE;
						end else begin
							mul_req_q <= '{start: 1'b1, a: abs_z(z0_re_x), b: abs_z(z0_re_x)};
							state_q   <= ST_SQ_RE;
						end
					end
				end
				ST_SQ_RE: begin
					if (mul_rsp.done) begin
						rr_q      <= sq_zcap;
						mre_q     <= sq_mcap;
						mul_req_q <= '{start: 1'b1, a: abs_z(im_q), b: abs_z(im_q)};
						state_q   <= ST_SQ_IM;
					end
				end
				ST_SQ_IM: begin
					if (mul_rsp.done) begin
						ii_q    <= sq_zcap;
						mag_q   <= MSUM_W'(mre_q) + MSUM_W'(sq_mcap);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!first_q && mag_q > thr) begin
						esc_flag_q <= 1'b1;
						log_req_q  <= '{start: 1'b1, x: mag_q, frac: POS_W'(COORD_FRAC_BITS)};
						state_q    <= ST_LOG_MAG;
					end else begin
						counter_q <= cnt_nx;
						first_q   <= 1'b0;
						if (cnt_nx == limit_q) begin
							state_q <= ST_DONE;
						end else begin
							mul_req_q <= '{start: 1'b1, a: abs_z(re_q), b: abs_z(im_q)};
							state_q   <= ST_CROSS;
						end
					end
				end
				ST_CROSS: begin
					if (mul_rsp.done) begin
						ri_q    <= ri;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					re_q      <= nre;
					im_q      <= nim;
					mul_req_q <= '{start: 1'b1, a: abs_z(nre), b: abs_z(nre)};
					state_q   <= ST_SQ_RE;
				end
				ST_LOG_MAG: begin
					if (log_rsp.done) begin
						log_req_q <= '{start: 1'b1, x: MSUM_W'(lg_pos), frac: POS_W'(FRAC_Q)};
						state_q   <= ST_LOG_L;
					end
				end
				ST_LOG_L: begin
					if (log_rsp.done) begin
						smooth_res_q <= smooth_full[SMOOTH_W-1:0];
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						iteration_count_q <= CNT_OUT_W'(counter_q);
						escaped_q         <= esc_flag_q;
						smooth_value_q    <= esc_flag_q ? smooth_res_q :
						                     SMOOTH_W'({counter_q, {FRAC_Q{1'b0}}});
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign iteration_count = iteration_count_q;
	assign escaped         = escaped_q;
	assign smooth_value    = smooth_value_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> counter_q <= limit_q)
		else $error("iteration count passed the limit");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> (esc_flag_q && counter_q < limit_q) ||
		                       (!esc_flag_q && counter_q == limit_q))
		else $error("result count inconsistent with escape flag");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == ST_SQ_RE || state_q == ST_SQ_IM || state_q == ST_CROSS)
		else $error("product returned outside a multiply state");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for julia_escape_time_smooth_unit: directed and random start points
// over several c / radius / limit settings, checked against an in-bench escape-time predictor.
// Depends on jets_pkg and the unit itself.
module tb_top;
	import jets_pkg::*;

	localparam int          FRAC        = COORD_FRAC_BITS;
	localparam int          LOG_D       = LOG_TABLE_DEPTH;
	localparam longint      Z_HI        = (64'sd1 <<< (FRAC + 19)) - 1;
	localparam longint      Z_LO        = -Z_HI - 1;
	localparam longint      SQ_LIM      = 64'sd1 <<< 62;
	localparam longint      LN2_TERM    = 34653;
	localparam int          HOLD_CYCLES = 3000;
	localparam int          QUIET_LIMIT = 40000;

	typedef struct packed {
		logic signed [COORD_W-1:0] re;
		logic signed [COORD_W-1:0] im;
	} point_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0]       count;
		logic                       esc;
		logic signed [SMOOTH_W-1:0] smooth;
	} pixel_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [COORD_W-1:0]  z0_re     = '0;
	logic signed [COORD_W-1:0]  z0_im     = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [CNT_OUT_W-1:0]       iteration_count;
	logic                       escaped;
	logic signed [SMOOTH_W-1:0] smooth_value;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	cfg_reg_t                   cfg_index = REG_C_RE;
	logic [CFG_W-1:0]           cfg_data  = '0;

	// predictor's copy of the registers
	longint      c_re_cfg   = 0;
	longint      c_im_cfg   = 0;
	int unsigned cfg_radius = 4;
	int unsigned cfg_limit  = 256;
	int unsigned frac_log [LOG_D];

	point_t pending_points [$];
	pixel_t due_results [$];
	int     n_queued    = 0;
	int     n_results   = 0;
	int     errors      = 0;
	int     tx_max_gap  = 11;
	int     rx_max_gap  = 11;
	int     tx_left     = 0;
	int     rx_left     = 0;
	int     hold_left   = 0;
	logic   hold_arm    = 1'b0;
	logic   hold_seen   = 1'b0;
	int     quiet_cycles = 0;

	julia_escape_time_smooth_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.z0_re           (z0_re),
		.z0_im           (z0_im),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.iteration_count (iteration_count),
		.escaped         (escaped),
		.smooth_value    (smooth_value),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint sat_z(longint v);
		if (v > Z_HI) return Z_HI;
		if (v < Z_LO) return Z_LO;
		return v;
	endfunction

	function automatic longint unsigned mag_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// (a*b) >> FRAC, clipped to cap
	function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
	                                              longint unsigned cap);
		logic [127:0] q;
		q = ({64'd0, a} * {64'd0, b}) >> FRAC;
		if (q[127:64] != 0) return cap;
		return (q[63:0] > cap) ? cap : q[63:0];
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic            neg;
		longint unsigned m;
		neg = (a < 0) != (b < 0);
		m = mul_shift(mag_of(a), mag_of(b), neg ? Z_HI + 1 : Z_HI);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// log2(1 + k/D) in Q16.16, squaring in Q1.30
	function automatic int unsigned log_frac(int k);
		longint unsigned v;
		int unsigned     r;
		v = (64'd1 << 30) + ((longint'(k) << 30) / LOG_D);
		r = 0;
		repeat (17) begin
			v = (v * v) >> 30;
			r = r << 1;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				r = r | 1;
			end
		end
		return (r + 1) >> 1;
	endfunction

	function automatic longint log2_q16(longint unsigned x, int frac);
		int              p;
		longint unsigned f;
		longint unsigned idx;
		p = 63;
		while (x[p] == 1'b0) p--;
		x = (p < 62) ? x << (62 - p) : x >> (p - 62);
		f = x - (64'd1 << 62);
		idx = ((f >> 30) * LOG_D) >> 32;
		if (idx >= LOG_D) idx = LOG_D - 1;
		return longint'(p - frac) * 65536 + longint'(frac_log[idx]);
	endfunction

	function automatic pixel_t escape_time(logic signed [COORD_W-1:0] zr,
	                                       logic signed [COORD_W-1:0] zi);
		pixel_t          res;
		longint          re;
		longint          im;
		longint          nre;
		longint          nim;
		longint          lg;
		longint          smooth;
		longint unsigned m;
		longint unsigned thr;
		int unsigned     it;
		logic            esc;
		re = zr;
		im = zi;
		thr = longint'(cfg_radius) << FRAC;
		it = 0;
		esc = 1'b0;
		m = 0;
		while (it < cfg_limit && !esc) begin
			nre = sat_z(sat_z(fx_mul(re, re) - fx_mul(im, im)) + c_re_cfg);
			nim = sat_z(sat_z(2 * fx_mul(re, im)) + c_im_cfg);
			re = nre;
			im = nim;
			m = mul_shift(mag_of(re), mag_of(re), SQ_LIM) + mul_shift(mag_of(im), mag_of(im), SQ_LIM);
			if (m > thr) esc = 1'b1;
			else it++;
		end
		if (esc) begin
			lg = log2_q16(m, FRAC);
			if (lg <= 0) lg = 1;
			smooth = longint'(it) * 65536 + 131072 - log2_q16(lg, 16) + LN2_TERM;
		end else begin
			smooth = longint'(it) * 65536;
		end
		res.count  = it[CNT_OUT_W-1:0];
		res.esc    = esc;
		res.smooth = smooth[SMOOTH_W-1:0];
		return res;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return $signed($urandom) >>> 10;
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return 32'sh0;
					3: return -32'sd1;
					default: return 32'sh10000000;
				endcase
			end
			default: return $signed($urandom) >>> 2;
		endcase
	endfunction

	task automatic queue_point(logic [COORD_W-1:0] re, logic [COORD_W-1:0] im);
		point_t p;
		p.re = re;
		p.im = im;
		pending_points.push_back(p);
		n_queued++;
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_C_RE:       c_re_cfg   = longint'($signed(val));
			REG_C_IM:       c_im_cfg   = longint'($signed(val));
			REG_ESC_RADIUS: cfg_radius = val[THR_W-1:0];
			REG_MAX_ITER:   cfg_limit  = val[LIMIT_W-1:0];
		endcase
	endtask

	// only called once every outstanding result is back
	task automatic load_regs(logic [31:0] cre, logic [31:0] cim, int rad, int lim);
		cfg_write(REG_C_RE, cre);
		cfg_write(REG_C_IM, cim);
		cfg_write(REG_ESC_RADIUS, rad);
		cfg_write(REG_MAX_ITER, lim);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (n_results < n_queued) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin : tx_side
		if (arst_n) begin
			if (in_valid && in_ready) due_results.push_back(escape_time(z0_re, z0_im));
			if (!in_valid || in_ready) begin
				if (tx_left != 0) begin
					in_valid <= 1'b0;
					tx_left <= tx_left - 1;
				end else if (pending_points.size() != 0) begin
					point_t nxt;
					nxt = pending_points.pop_front();
					in_valid <= 1'b1;
					z0_re <= nxt.re;
					z0_im <= nxt.im;
					tx_left <= $urandom_range(0, tx_max_gap);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : rx_side
		pixel_t want;
		int     gap;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (due_results.size() == 0) begin
					$error("result item with nothing outstanding");
					errors++;
				end else begin
					want = due_results.pop_front();
					if (iteration_count !== want.count) begin
						$error("iteration_count: expected %0d, got %0d", want.count, iteration_count);
						errors++;
					end
					if (escaped !== want.esc) begin
						$error("escaped: expected %0d, got %0d", want.esc, escaped);
						errors++;
					end
					if (smooth_value !== want.smooth) begin
						$error("smooth_value: expected %0d, got %0d", $signed(want.smooth),
						       smooth_value);
						errors++;
					end
				end
			end
			if (hold_arm != hold_seen) begin
				hold_seen <= hold_arm;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else if (out_valid && out_ready) begin
				gap = $urandom_range(0, rx_max_gap);
				if (gap == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					rx_left <= gap - 1;
				end
			end else if (!out_ready) begin
				if (rx_left == 0) out_ready <= 1'b1;
				else rx_left <= rx_left - 1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] cre;
		logic [31:0] cim;
		logic [31:0] re;
		int          rad;
		int          lim;
		for (int k = 0; k < LOG_D; k++) frac_log[k] = log_frac(k);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: c = 0, radius 4, limit 256
		queue_point(32'h00000000, 32'h00000000);
		queue_point(32'h10000000, 32'h00000000);
		queue_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		queue_point(32'h80000000, 32'h80000000);
		queue_point(32'h80000000, 32'h7FFFFFFF);
		queue_point(32'h7FFFFFFF, 32'h80000000);
		queue_point(32'h18000000, 32'h00000000);
		queue_point(32'h20000000, 32'h00000000);
		queue_point(32'h00000000, 32'hF8000000);
		queue_point(32'hFFFFFFFF, 32'h00000001);
		drain();

		// extreme c, radius 65536
		tx_max_gap = 0;
		load_regs(32'h80000000, 32'h7FFFFFFF, 65536, 64);
		queue_point(32'h00000000, 32'h00000000);
		queue_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		queue_point(32'h20000000, 32'hE0000000);
		drain();
		load_regs(32'h7FFFFFFF, 32'h80000000, 65536, 64);
		queue_point(32'h00000000, 32'h00000000);
		drain();

		// top limit; |z0| >= 2 with c = 0 escapes within a few rounds
		rx_max_gap = 0;
		load_regs(32'h0, 32'h0, 65536, 65535);
		queue_point(32'h20000000, 32'h00000000);
		queue_point(32'h00000000, 32'hE0000000);
		queue_point(32'h80000000, 32'h80000000);
		queue_point(32'h7FFFFFFF, 32'h12345678);
		drain();

		// zero limit, then zero threshold with tiny magnitudes
		tx_max_gap = 11;
		load_regs(32'h0, 32'h0, 0, 0);
		queue_point(32'h00000000, 32'h00000000);
		queue_point(32'h7FFFFFFF, 32'h80000000);
		drain();
		load_regs(32'h0, 32'h0, 0, 1);
		queue_point(32'h00000000, 32'h00000000);
		queue_point(32'h01000000, 32'h00000000);
		queue_point(32'h00004000, 32'hFFFFC000);
		queue_point(32'h10000000, 32'h00000000);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(0, 3) == 0) cre = $urandom;
			else cre = $signed($urandom) >>> 3;
			if ($urandom_range(0, 3) == 0) cim = $urandom;
			else cim = $signed($urandom) >>> 3;
			case ($urandom_range(0, 6))
				0: rad = 0;
				1: rad = 1;
				2: rad = 2;
				3: rad = 4;
				4: rad = 65536;
				default: rad = $urandom_range(1, 65536);
			endcase
			if ($urandom_range(0, 3) == 0) lim = $urandom_range(21, 64);
			else lim = $urandom_range(1, 20);
			tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
			rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
			if (ph == 2) begin
				lim = $urandom_range(1, 8);
				tx_max_gap = 0;
			end
			load_regs(cre, cim, rad, lim);
			for (int k = 0; k < 73; k++) begin
				if (ph == 11 && k < 6) begin
					// large start points keep the top limit cheap
					if (k == 0) begin
						drain();
						load_regs(32'h0, 32'h0, 65536, 65535);
					end
					re = $urandom_range(32'h7FFFFFFF, 32'h20000000);
					if ($urandom_range(0, 1)) re = -re;
					queue_point(re, rand_coord());
					if (k == 5) begin
						drain();
						load_regs(cre, cim, rad, lim);
					end
				end else begin
					queue_point(rand_coord(), rand_coord());
				end
			end
			if (ph == 2) hold_arm = ~hold_arm;
			drain();
		end

		repeat (100) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d expected result items never arrived", due_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/jets_pkg.sv
rtl/jets_mul.sv
rtl/jets_log2.sv
rtl/julia_escape_time_smooth_unit.sv
tb/tb_top.sv
